// ----- rtl/ctli_pkg.sv -----
// ----------------------------------------------------------------------------
// ctli_pkg
// shared widths, register indexes and types for the trilinear interpolation core
// ----------------------------------------------------------------------------
package ctli_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int FRAC_WIDTH  = 16;
  localparam int NUM_CORNERS = 8;

  // sum of up to three corner values and its magnitude
  localparam int SUM_WIDTH = VALUE_WIDTH + 2;
  localparam int MAG_WIDTH = VALUE_WIDTH + 1;

  // divide by three as a multiply by a reciprocal, exact for magnitudes below 2^MAG_WIDTH
  localparam int DIV3_SHIFT = VALUE_WIDTH + 2;
  localparam logic [MAG_WIDTH-1:0] DIV3_MUL =
    MAG_WIDTH'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

  // stream payload widths
  localparam int IN_DATA_BITS   = NUM_CORNERS * VALUE_WIDTH + 3 * FRAC_WIDTH;
  localparam int IN_DATA_WIDTH  = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = 3 * VALUE_WIDTH;
  localparam int OUT_DATA_WIDTH = ((OUT_DATA_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEFAULT_VALUE      = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXTRAPOLATE_ENABLE = 2'd1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    DIV_1,
    DIV_2,
    DIV_3
  } div_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] sum;
    div_t                        div;
  } fill_t;

  // load enables of the two register ranks of one lerp unit
  typedef struct packed {
    logic mul;
    logic add;
  } lerp_en_t;

endpackage

// ----- rtl/ctli_lerp.sv -----
// ----------------------------------------------------------------------------
// ctli_lerp
// one registered lerp step: a + round((b - a) * f / 2^FRAC_WIDTH)
// ----------------------------------------------------------------------------
module ctli_lerp
  import ctli_pkg::*;
(
  input  logic                  clk,
  input  lerp_en_t              en,
  input  value_t                a,
  input  value_t                b,
  input  logic [FRAC_WIDTH-1:0] frac,
  output value_t                y
);

  localparam int PROD_WIDTH = VALUE_WIDTH + FRAC_WIDTH + 2;
  localparam logic signed [PROD_WIDTH-1:0] HALF =
    {{(PROD_WIDTH - FRAC_WIDTH){1'b0}}, 1'b1, {(FRAC_WIDTH - 1){1'b0}}};

  logic signed [VALUE_WIDTH:0]    diff;
  logic signed [FRAC_WIDTH:0]     frac_s;
  logic signed [PROD_WIDTH-1:0]   prod;
  value_t                         a_q;
  logic signed [PROD_WIDTH-1:0]   rounded;
  logic signed [PROD_WIDTH-1:0]   shifted;
  logic signed [VALUE_WIDTH+1:0]  total;

  assign diff   = $signed({b[VALUE_WIDTH-1], b}) - $signed({a[VALUE_WIDTH-1], a});
  assign frac_s = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod <= PROD_WIDTH'(diff * frac_s);
      a_q  <= a;
    end
  end

  // floor shift, ties go up
  assign rounded = prod + HALF;
  assign shifted = rounded >>> FRAC_WIDTH;
  assign total   = $signed({{2{a_q[VALUE_WIDTH-1]}}, a_q}) + shifted[VALUE_WIDTH+1:0];

  always_ff @(posedge clk) begin
    if (en.add) begin
      y <= total[VALUE_WIDTH-1:0];
    end
  end

endmodule

// ----- rtl/collidable_trilinear_interpolation_core.sv -----
// ----------------------------------------------------------------------------
// collidable_trilinear_interpolation_core
// trilinear interpolation of one cube cell with invalid-corner filling
// ----------------------------------------------------------------------------
// One transaction on the slave stream carries eight signed corner samples, a
// corner validity mask (tuser) and three unsigned fractional positions; one
// transaction on the master stream returns the rounded trilinear value, the
// min and max of the filled corners, and a valid flag (tuser) that is set when
// any corner was valid. Invalid corners take default_value; with
// extrapolate_enable set and a partly valid mask they are filled from the mean
// of valid edge neighbours, else face-diagonal neighbours, else the opposite
// corner. The core is an 11-stage pipeline: a new transaction can enter every
// cycle unless every stage is full and the master side stalls, and each one
// passes through the stages in order before its master transaction is sent.
// The depth comes from the fill path (select, magnitude, divide-by-three
// multiply, sign restore) followed by three lerp units of two stages each.
// Stage-wise ready lets bubbles close up, so input keeps being taken while a
// finished result waits on the master side. Configuration writes take effect
// for transactions not yet past stage 1 and are meant to be done while idle.
// ----------------------------------------------------------------------------
module collidable_trilinear_interpolation_core
  import ctli_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // slave stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // corner_value_0 .. corner_value_7, frac_x, frac_y, frac_z
  input  logic [IN_DATA_WIDTH-1:0]   s_tdata,
  // valid_corners
  input  logic [NUM_CORNERS-1:0]     s_tuser,
  // master stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // interpolated_value, min_value, max_value
  output logic [OUT_DATA_WIDTH-1:0]  m_tdata,
  // result_valid
  output logic                       m_tuser,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [VALUE_WIDTH-1:0]     cfg_data
);

  localparam int NUM_STAGES = 11;

  // configuration registers
  value_t default_value;
  logic   extrapolate_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value      <= '0;
      extrapolate_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEFAULT_VALUE:      default_value      <= cfg_data;
        CFG_EXTRAPOLATE_ENABLE: extrapolate_enable <= cfg_data[0];
        default:                ;
      endcase
    end
  end

  // pipeline flow control: a stage loads when it is empty or its successor loads
  logic [NUM_STAGES:1]   valid;
  logic [NUM_STAGES+1:1] ready;

  always_comb begin
    ready[NUM_STAGES+1] = m_tready;
    for (int i = NUM_STAGES; i >= 1; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[1]) begin
        valid[1] <= s_tvalid;
      end
      for (int i = 2; i <= NUM_STAGES; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign s_tready = ready[1];
  assign m_tvalid = valid[NUM_STAGES];

  // side-band carried down the pipe
  logic [FRAC_WIDTH-1:0] fx_q [1:5];
  logic [FRAC_WIDTH-1:0] fy_q [1:7];
  logic [FRAC_WIDTH-1:0] fz_q [1:9];
  logic                  rv_q [2:NUM_STAGES];

  // stage 1: input capture
  value_t                 corner_q [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] mask_q;

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      for (int t = 0; t < NUM_CORNERS; t++) begin
        corner_q[t] <= s_tdata[t*VALUE_WIDTH +: VALUE_WIDTH];
      end
      mask_q  <= s_tuser;
      fx_q[1] <= s_tdata[NUM_CORNERS*VALUE_WIDTH +: FRAC_WIDTH];
      fy_q[1] <= s_tdata[NUM_CORNERS*VALUE_WIDTH + FRAC_WIDTH +: FRAC_WIDTH];
      fz_q[1] <= s_tdata[NUM_CORNERS*VALUE_WIDTH + 2*FRAC_WIDTH +: FRAC_WIDTH];
    end
  end

  // stage 2: pick each corner's source sum and divisor
  function automatic logic signed [SUM_WIDTH-1:0] sx(input value_t v);
    sx = SUM_WIDTH'(v);
  endfunction

  function automatic div_t cnt_to_div(input logic [1:0] cnt);
    div_t d;
    case (cnt)
      2'd2:    d = DIV_2;
      2'd3:    d = DIV_3;
      default: d = DIV_1;
    endcase
    return d;
  endfunction

  fill_t fill [NUM_CORNERS];

  always_comb begin
    logic                        partial;
    logic [2:0]                  tb;
    logic [2:0]                  nb;
    logic [2:0]                  fb;
    logic signed [SUM_WIDTH-1:0] esum;
    logic signed [SUM_WIDTH-1:0] fsum;
    logic [1:0]                  ecnt;
    logic [1:0]                  fcnt;
    partial = extrapolate_enable && (mask_q != '0) && (mask_q != '1);
    for (int t = 0; t < NUM_CORNERS; t++) begin
      tb   = 3'(t);
      esum = '0;
      fsum = '0;
      ecnt = '0;
      fcnt = '0;
      for (int n = 0; n < 3; n++) begin
        nb = tb ^ (3'd1 << n);
        fb = nb ^ 3'd7;
        if (mask_q[nb]) begin
          esum = esum + sx(corner_q[nb]);
          ecnt = ecnt + 2'd1;
        end
        if (mask_q[fb]) begin
          fsum = fsum + sx(corner_q[fb]);
          fcnt = fcnt + 2'd1;
        end
      end
      if (mask_q[t]) begin
        fill[t] = '{sum: sx(corner_q[t]), div: DIV_1};
      end else if (!partial) begin
        fill[t] = '{sum: sx(default_value), div: DIV_1};
      end else if (ecnt != 2'd0) begin
        fill[t] = '{sum: esum, div: cnt_to_div(ecnt)};
      end else if (fcnt != 2'd0) begin
        fill[t] = '{sum: fsum, div: cnt_to_div(fcnt)};
      end else begin
        fill[t] = '{sum: sx(corner_q[tb ^ 3'd7]), div: DIV_1};
      end
    end
  end

  fill_t fill_q [NUM_CORNERS];

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      fill_q   <= fill;
      rv_q[2]  <= (mask_q != '0);
      fx_q[2]  <= fx_q[1];
      fy_q[2]  <= fy_q[1];
      fz_q[2]  <= fz_q[1];
    end
  end

  // stage 3: sign and magnitude, so the mean truncates toward zero
  logic [MAG_WIDTH-1:0] mag3 [NUM_CORNERS];
  logic                 neg3 [NUM_CORNERS];
  div_t                 div3 [NUM_CORNERS];

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      for (int t = 0; t < NUM_CORNERS; t++) begin
        neg3[t] <= fill_q[t].sum[SUM_WIDTH-1];
        mag3[t] <= fill_q[t].sum[SUM_WIDTH-1] ? MAG_WIDTH'(-fill_q[t].sum)
                                              : MAG_WIDTH'(fill_q[t].sum);
        div3[t] <= fill_q[t].div;
      end
      rv_q[3] <= rv_q[2];
      fx_q[3] <= fx_q[2];
      fy_q[3] <= fy_q[2];
      fz_q[3] <= fz_q[2];
    end
  end

  // stage 4: reciprocal multiply for the three-source mean
  logic [2*MAG_WIDTH-1:0] prod4 [NUM_CORNERS];
  logic [MAG_WIDTH-1:0]   mag4  [NUM_CORNERS];
  logic                   neg4  [NUM_CORNERS];
  div_t                   div4  [NUM_CORNERS];

  always_ff @(posedge clk) begin
    if (ready[4]) begin
      for (int t = 0; t < NUM_CORNERS; t++) begin
        prod4[t] <= mag3[t] * DIV3_MUL;
        mag4[t]  <= mag3[t];
        neg4[t]  <= neg3[t];
        div4[t]  <= div3[t];
      end
      rv_q[4] <= rv_q[3];
      fx_q[4] <= fx_q[3];
      fy_q[4] <= fy_q[3];
      fz_q[4] <= fz_q[3];
    end
  end

  // stage 5: quotient select and sign restore give the filled corners
  value_t v5 [NUM_CORNERS];

  always_ff @(posedge clk) begin
    logic [MAG_WIDTH-1:0] q;
    if (ready[5]) begin
      for (int t = 0; t < NUM_CORNERS; t++) begin
        case (div4[t])
          DIV_3:   q = MAG_WIDTH'(prod4[t] >> DIV3_SHIFT);
          DIV_2:   q = mag4[t] >> 1;
          default: q = mag4[t];
        endcase
        v5[t] <= neg4[t] ? VALUE_WIDTH'(-q) : VALUE_WIDTH'(q);
      end
      rv_q[5] <= rv_q[4];
      fx_q[5] <= fx_q[4];
      fy_q[5] <= fy_q[4];
      fz_q[5] <= fz_q[4];
    end
  end

  // stages 6..11: lerp along x, y, z; extrema reduced alongside
  value_t lx [4];
  value_t ly [2];
  value_t lz;

  for (genvar k = 0; k < 4; k++) begin : g_lerp_x
    ctli_lerp u_lerp_x (
      .clk  (clk),
      .en   ('{mul: ready[6], add: ready[7]}),
      .a    (v5[2*k]),
      .b    (v5[2*k+1]),
      .frac (fx_q[5]),
      .y    (lx[k])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_lerp_y
    ctli_lerp u_lerp_y (
      .clk  (clk),
      .en   ('{mul: ready[8], add: ready[9]}),
      .a    (lx[2*k]),
      .b    (lx[2*k+1]),
      .frac (fy_q[7]),
      .y    (ly[k])
    );
  end

  ctli_lerp u_lerp_z (
    .clk  (clk),
    .en   ('{mul: ready[10], add: ready[11]}),
    .a    (ly[0]),
    .b    (ly[1]),
    .frac (fz_q[9]),
    .y    (lz)
  );

  value_t mn6 [4];
  value_t mx6 [4];
  value_t mn7 [2];
  value_t mx7 [2];
  value_t mn_q [8:NUM_STAGES];
  value_t mx_q [8:NUM_STAGES];

  always_ff @(posedge clk) begin
    if (ready[6]) begin
      for (int k = 0; k < 4; k++) begin
        mn6[k] <= (v5[2*k] < v5[2*k+1]) ? v5[2*k] : v5[2*k+1];
        mx6[k] <= (v5[2*k] > v5[2*k+1]) ? v5[2*k] : v5[2*k+1];
      end
      rv_q[6] <= rv_q[5];
      fy_q[6] <= fy_q[5];
      fz_q[6] <= fz_q[5];
    end
    if (ready[7]) begin
      for (int k = 0; k < 2; k++) begin
        mn7[k] <= (mn6[2*k] < mn6[2*k+1]) ? mn6[2*k] : mn6[2*k+1];
        mx7[k] <= (mx6[2*k] > mx6[2*k+1]) ? mx6[2*k] : mx6[2*k+1];
      end
      rv_q[7] <= rv_q[6];
      fy_q[7] <= fy_q[6];
      fz_q[7] <= fz_q[6];
    end
    if (ready[8]) begin
      mn_q[8] <= (mn7[0] < mn7[1]) ? mn7[0] : mn7[1];
      mx_q[8] <= (mx7[0] > mx7[1]) ? mx7[0] : mx7[1];
      rv_q[8] <= rv_q[7];
      fz_q[8] <= fz_q[7];
    end
    if (ready[9]) begin
      fz_q[9] <= fz_q[8];
    end
    for (int i = 9; i <= NUM_STAGES; i++) begin
      if (ready[i]) begin
        mn_q[i] <= mn_q[i-1];
        mx_q[i] <= mx_q[i-1];
        rv_q[i] <= rv_q[i-1];
      end
    end
  end

  // output register is the last pipeline stage
  assign m_tdata = OUT_DATA_WIDTH'({mx_q[NUM_STAGES], mn_q[NUM_STAGES], lz});
  assign m_tuser = rv_q[NUM_STAGES];

`ifndef SYNTH
  // trilinear result stays within the filled corners' range
  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (mn_q[NUM_STAGES] <= lz) && (lz <= mx_q[NUM_STAGES]))
    else $error("interpolated value outside min/max of filled corners");

  // with no valid corner every corner is the default value
  a_all_default_flat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (mn_q[NUM_STAGES] == mx_q[NUM_STAGES])
                               && (lz == mn_q[NUM_STAGES]))
    else $error("result with no valid corner is not flat");

  // input is only held off when every stage is full and the output is stalled
  a_backpressure_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (valid == '1) && !m_tready)
    else $error("input stalled while pipeline has a bubble");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output transaction valid right after reset");
`endif

endmodule
